/* rtl/ppf_pkg.sv */
// ppf_pkg: shared types and constants of the pedal packet framer
// used by every module of the block; depends on nothing

package ppf_pkg;

	localparam int unsigned PEDAL_W   = 12;
	localparam int unsigned TIMEOUT_W = 8;
	localparam int unsigned TICKS_W   = 9;
	localparam int unsigned SEQ_W     = 8;
	localparam int unsigned CFG_W     = 12;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned BYTE_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_MAX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;

	localparam logic [PEDAL_W-1:0]   PEDAL_MAX_RST = 12'd3000;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 8'd50;
	localparam logic [TICKS_W-1:0]   TICKS_SAT     = 9'd511;

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [7:0] HDR_BYTE    = 8'hAA;
	localparam logic [7:0] TAIL_BYTE   = 8'hED;
	localparam logic [7:0] STATUS_BYTE = 8'h00;
	localparam logic [7:0] RSVD_BYTE   = 8'h00;
	localparam logic [BYTE_IDX_W-1:0] FRAME_LAST = 3'd7;

	typedef struct packed {
		logic               kind;
		logic [PEDAL_W-1:0] accel_sample;
		logic [PEDAL_W-1:0] brake_sample;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       byte_valid;
		logic       last_byte;
		logic       data_ready;
		logic       timed_out;
	} result_t;

	// work for the back end: one frame or one status-only result
	typedef struct packed {
		logic               is_frame;
		logic [PEDAL_W-1:0] pedal;
		logic [SEQ_W-1:0]   seq;
		logic               data_ready;
		logic               timed_out;
	} cmd_t;

	localparam int unsigned CMD_W = $bits(cmd_t);

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

/* rtl/ppf_front.sv */
// ppf_front: accepts items, keeps busy/sequence/tick state and config registers
// classifies each item into a command for the queue; depends on ppf_pkg

module ppf_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  ppf_pkg::item_t                       item,
	input  logic                                 cfg_we,
	input  logic [ppf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ppf_pkg::CFG_W-1:0]            cfg_wdata,
	input  ppf_pkg::queue_status_t               q_status,
	output logic                                 push,
	output ppf_pkg::cmd_t                        cmd
);

	logic                            busy_q;
	logic [ppf_pkg::SEQ_W-1:0]       seq_q;
	logic [ppf_pkg::TICKS_W-1:0]     ticks_q;
	logic [ppf_pkg::PEDAL_W-1:0]     pedal_max_q;
	logic [ppf_pkg::TIMEOUT_W-1:0]   timeout_q;

	logic                            accept;
	logic [ppf_pkg::TICKS_W-1:0]     ticks_inc;
	logic                            expire;
	logic [ppf_pkg::PEDAL_W:0]       diff;
	logic [ppf_pkg::PEDAL_W-1:0]     pedal;

	assign item_stall = q_status.full;
	assign accept     = item_valid && !q_status.full;
	assign push       = accept;

	assign ticks_inc = (ticks_q == ppf_pkg::TICKS_SAT) ? ticks_q : ticks_q + 1'b1;
	assign expire    = ticks_inc > {1'b0, timeout_q};

	// 13-bit difference, top bit set means brake above accel
	assign diff  = {1'b0, item.accel_sample} - {1'b0, item.brake_sample};
	assign pedal = diff[ppf_pkg::PEDAL_W] ? '0 :
		(diff[ppf_pkg::PEDAL_W-1:0] > pedal_max_q) ? pedal_max_q :
		diff[ppf_pkg::PEDAL_W-1:0];

	always_comb begin
		cmd            = '0;
		cmd.pedal      = pedal;
		cmd.seq        = seq_q;
		if (item.kind == ppf_pkg::KIND_DONE) begin
			cmd.is_frame   = 1'b0;
			cmd.data_ready = 1'b0;
			cmd.timed_out  = 1'b0;
		end else if (busy_q) begin
			cmd.is_frame   = 1'b0;
			cmd.data_ready = !expire;
			cmd.timed_out  = expire;
		end else begin
			cmd.is_frame   = 1'b1;
			cmd.data_ready = 1'b1;
			cmd.timed_out  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			seq_q   <= '0;
			ticks_q <= '0;
		end else if (accept) begin
			if (item.kind == ppf_pkg::KIND_DONE) begin
				busy_q  <= 1'b0;
				ticks_q <= '0;
			end else if (busy_q) begin
				if (expire) begin
					busy_q  <= 1'b0;
					ticks_q <= '0;
				end else begin
					ticks_q <= ticks_inc;
				end
			end else begin
				busy_q  <= 1'b1;
				ticks_q <= '0;
				seq_q   <= seq_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedal_max_q <= ppf_pkg::PEDAL_MAX_RST;
			timeout_q   <= ppf_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ppf_pkg::CFG_PEDAL_MAX: pedal_max_q <= cfg_wdata;
				ppf_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_wdata[ppf_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/ppf_queue.sv */
// ppf_queue: short register queue of commands between front and back end
// depends on ppf_pkg

module ppf_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ppf_pkg::cmd_t          wdata,
	input  logic                   pop,
	output ppf_pkg::cmd_t          rdata,
	output ppf_pkg::queue_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ppf_pkg::cmd_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = cnt_q == CNT_FULL;
	assign status.empty = cnt_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rdata        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/ppf_back.sv */
// ppf_back: turns queued commands into results, one per cycle while a command is queued and the output is not stalled,
// into an output register; frames are serialized byte by byte; depends on ppf_pkg

module ppf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ppf_pkg::cmd_t          head,
	input  ppf_pkg::queue_status_t q_status,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output ppf_pkg::result_t       result
);

	logic [ppf_pkg::BYTE_IDX_W-1:0] idx_q;
	logic                           out_valid_q;
	ppf_pkg::result_t               out_q;
	logic                           slot_free;
	logic                           emit;
	logic                           last;
	logic [7:0]                     lo_byte;
	logic [7:0]                     hi_byte;
	logic [7:0]                     sum_byte;
	logic [7:0]                     byte_sel;
	ppf_pkg::result_t               nxt;

	assign slot_free = !out_valid_q || !result_stall;
	assign emit      = slot_free && !q_status.empty;
	assign last      = !head.is_frame || (idx_q == ppf_pkg::FRAME_LAST);
	assign pop       = emit && last;

	assign lo_byte  = head.pedal[7:0];
	assign hi_byte  = {{(16 - ppf_pkg::PEDAL_W){1'b0}}, head.pedal[ppf_pkg::PEDAL_W-1:8]};
	assign sum_byte = ppf_pkg::HDR_BYTE ^ lo_byte ^ hi_byte ^ ppf_pkg::STATUS_BYTE
		^ head.seq ^ ppf_pkg::RSVD_BYTE;

	// frame order: header, data low, data high, status, sequence, reserved, xor, tail
	always_comb begin
		case (idx_q)
			3'd0:    byte_sel = ppf_pkg::HDR_BYTE;
			3'd1:    byte_sel = lo_byte;
			3'd2:    byte_sel = hi_byte;
			3'd3:    byte_sel = ppf_pkg::STATUS_BYTE;
			3'd4:    byte_sel = head.seq;
			3'd5:    byte_sel = ppf_pkg::RSVD_BYTE;
			3'd6:    byte_sel = sum_byte;
			default: byte_sel = ppf_pkg::TAIL_BYTE;
		endcase
	end

	always_comb begin
		nxt.frame_byte = head.is_frame ? byte_sel : 8'h00;
		nxt.byte_valid = head.is_frame;
		nxt.last_byte  = last;
		nxt.data_ready = head.data_ready;
		nxt.timed_out  = head.timed_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			idx_q       <= last ? '0 : idx_q + 1'b1;
		end else if (slot_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= nxt;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* rtl/pedal_packet_framer.sv */
// pedal_packet_framer: an idle tick gives eight frame-byte results, every other item one
// the first result goes through the queue write at the transfer edge, then the output
// register; throughput: one item per cycle while the queue has room; an idle tick holds
// the back end until all eight frame bytes are out, other items for a single result
// reset clears busy, sequence, tick count, queue and output; config returns to
// pedal_max 3000 and timeout_ticks 50

module pedal_packet_framer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  ppf_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output ppf_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [ppf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppf_pkg::CFG_W-1:0]     cfg_wdata
);

	ppf_pkg::queue_status_t q_status;
	ppf_pkg::cmd_t          push_cmd;
	ppf_pkg::cmd_t          head_cmd;
	logic                   push;
	logic                   pop;

	ppf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.q_status   (q_status),
		.push       (push),
		.cmd        (push_cmd)
	);

	ppf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.rdata  (head_cmd),
		.status (q_status)
	);

	ppf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head_cmd),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* rtl/ppf_checker.sv */
// ppf_checker: port-level assertions for pedal_packet_framer, attached by bind
// depends on ppf_pkg and the top-level port list

module ppf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_stall,
	input ppf_pkg::item_t                item,
	input logic                          result_valid,
	input logic                          result_stall,
	input ppf_pkg::result_t              result
);

	// a stalled item holds
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled item changed");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// frame bytes go out only with data-ready high and no timeout
	a_frame_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_valid |-> result.data_ready && !result.timed_out)
		else $error("frame byte with wrong status flags");

	// a status-only result is the last of its item and carries a zero byte
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_valid |->
		result.last_byte && result.frame_byte == 8'h00 &&
		!(result.timed_out && result.data_ready))
		else $error("malformed status result");

	// the final byte of a frame is the tail marker
	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_valid && result.last_byte |->
		result.frame_byte == ppf_pkg::TAIL_BYTE)
		else $error("frame does not end in tail byte");

endmodule

bind pedal_packet_framer ppf_checker u_ppf_checker (.*);
